### rtl/gsoc_pkg.sv
// ---------------------------------------------------------------------------
// gsoc_pkg
// shared types and constants for the grid segment overlap counter
// ---------------------------------------------------------------------------
package gsoc_pkg;

   localparam int COORD_BITS_DEF = 10;   // default grid side is 2^10 cells
   localparam int IN_BITS        = 10;   // width of each coordinate port
   localparam int TOTAL_BITS     = 21;   // width of the overlap total

   localparam logic [1:0] HIT_ONE = 2'd1;
   localparam logic [1:0] HIT_SAT = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_FINISH
   } gsoc_state_type;

   typedef struct packed {
      logic clear;     // write zero at the clear address and advance it
      logic load;      // capture a new segment
      logic step;      // read the current cell and move to the next one
      logic publish;   // copy the total into the output register
   } gsoc_cmd_type;

   typedef struct packed {
      logic clear_last;   // clear address is at the last cell
      logic walk_last;    // current cell is the segment's last one
      logic out_free;     // output register can take a new result
   } gsoc_status_type;

endpackage

### rtl/gsoc_ctrl.sv
// ---------------------------------------------------------------------------
// gsoc_ctrl
// sequencer: clearing pass, segment walk, drain and result hand-off
// ---------------------------------------------------------------------------
module gsoc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  gsoc_pkg::gsoc_status_type status,
   output gsoc_pkg::gsoc_cmd_type    cmd
);

   gsoc_pkg::gsoc_state_type state_ff;
   gsoc_pkg::gsoc_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gsoc_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      case (state_ff)
         gsoc_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = gsoc_pkg::ST_IDLE;
            end
         end
         gsoc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = gsoc_pkg::ST_WALK;
            end
         end
         gsoc_pkg::ST_WALK: begin
            cmd.step = 1'b1;
            if (status.walk_last) begin
               state_in = gsoc_pkg::ST_DRAIN;
            end
         end
         gsoc_pkg::ST_DRAIN: begin
            // last write-back of the segment happens here
            state_in = gsoc_pkg::ST_FINISH;
         end
         gsoc_pkg::ST_FINISH: begin
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = gsoc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gsoc_pkg::ST_CLEAR;
         end
      endcase
   end

endmodule

### rtl/gsoc_dpath.sv
// ---------------------------------------------------------------------------
// gsoc_dpath
// cell walker, hit count memory with read-modify-write, total and output
// ---------------------------------------------------------------------------
module gsoc_dpath #(
   parameter int COORD_BITS = gsoc_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  gsoc_pkg::gsoc_cmd_type              cmd,
   output gsoc_pkg::gsoc_status_type           status,
   input  logic [gsoc_pkg::IN_BITS-1:0]        req_x_start,
   input  logic [gsoc_pkg::IN_BITS-1:0]        req_y_start,
   input  logic [gsoc_pkg::IN_BITS-1:0]        req_x_end,
   input  logic [gsoc_pkg::IN_BITS-1:0]        req_y_end,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [gsoc_pkg::TOTAL_BITS-1:0]     rsp_overlap_cells
);

   localparam int AW    = 2 * COORD_BITS;
   localparam int WB    = (COORD_BITS > gsoc_pkg::IN_BITS) ? COORD_BITS : gsoc_pkg::IN_BITS;
   localparam int CELLS = 1 << AW;
   localparam logic [gsoc_pkg::TOTAL_BITS-1:0] TOTAL_MAX = '1;

   // coordinate fit to grid width
   logic [WB-1:0]         xs_w, ys_w, xe_w, ye_w;
   logic [COORD_BITS-1:0] xs, ys, xe, ye;
   logic [COORD_BITS-1:0] dx, dy, span;
   logic                  xup, yup;

   assign xs_w = WB'(req_x_start);
   assign ys_w = WB'(req_y_start);
   assign xe_w = WB'(req_x_end);
   assign ye_w = WB'(req_y_end);
   assign xs   = xs_w[COORD_BITS-1:0];
   assign ys   = ys_w[COORD_BITS-1:0];
   assign xe   = xe_w[COORD_BITS-1:0];
   assign ye   = ye_w[COORD_BITS-1:0];

   assign xup = (xs <= xe);
   assign yup = (ys <= ye);
   assign dx  = xup ? (xe - xs) : (xs - xe);
   assign dy  = yup ? (ye - ys) : (ys - ye);

   // cells to visit after the first: min for diagonals, max otherwise
   always_comb begin
      if ((dx != '0) && (dy != '0)) begin
         span = (dx < dy) ? dx : dy;
      end else begin
         span = (dx > dy) ? dx : dy;
      end
   end

   // walker
   logic [COORD_BITS-1:0] x_ff, x_in, y_ff, y_in, remain_ff, remain_in;
   logic                  xmv_ff, xmv_in, ymv_ff, ymv_in, xup_ff, xup_in, yup_ff, yup_in;

   always_comb begin
      x_in      = x_ff;
      y_in      = y_ff;
      remain_in = remain_ff;
      xmv_in    = xmv_ff;
      ymv_in    = ymv_ff;
      xup_in    = xup_ff;
      yup_in    = yup_ff;
      if (cmd.load) begin
         x_in      = xs;
         y_in      = ys;
         remain_in = span;
         xmv_in    = (dx != '0);
         ymv_in    = (dy != '0);
         xup_in    = xup;
         yup_in    = yup;
      end else if (cmd.step) begin
         if (xmv_ff) begin
            x_in = xup_ff ? (x_ff + 1'b1) : (x_ff - 1'b1);
         end
         if (ymv_ff) begin
            y_in = yup_ff ? (y_ff + 1'b1) : (y_ff - 1'b1);
         end
         remain_in = remain_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      remain_ff <= remain_in;
      xmv_ff    <= xmv_in;
      ymv_ff    <= ymv_in;
      xup_ff    <= xup_in;
      yup_ff    <= yup_in;
   end

   // hit count memory: read a cell, write it back in the following cycle
   logic [1:0]    hit_mem [CELLS];
   logic [1:0]    rdata_ff;
   logic [AW-1:0] waddr_ff;
   logic          pend_ff;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [1:0]    wr_data;
   logic          bump;

   assign bump    = pend_ff && (rdata_ff < gsoc_pkg::HIT_SAT);
   assign wr_en   = cmd.clear || bump;
   assign wr_addr = cmd.clear ? clr_addr_ff : waddr_ff;
   assign wr_data = cmd.clear ? 2'd0 : (rdata_ff + 2'd1);

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         rdata_ff <= hit_mem[{y_ff, x_ff}];
         waddr_ff <= {y_ff, x_ff};
      end
      if (wr_en) begin
         hit_mem[wr_addr] <= wr_data;
      end
   end

   assign clr_addr_in = cmd.clear ? (clr_addr_ff + 1'b1) : clr_addr_ff;

   // overlap total and output register
   logic [gsoc_pkg::TOTAL_BITS-1:0] total_ff, total_in;
   logic [gsoc_pkg::TOTAL_BITS-1:0] out_ff, out_in;
   logic                            out_vld_ff, out_vld_in;

   always_comb begin
      total_in = total_ff;
      if (bump && (rdata_ff == gsoc_pkg::HIT_ONE) && (total_ff != TOTAL_MAX)) begin
         total_in = total_ff + 1'b1;
      end
   end

   always_comb begin
      out_in     = out_ff;
      out_vld_in = out_vld_ff;
      if (cmd.publish) begin
         out_in     = total_ff;
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff     <= 1'b0;
         clr_addr_ff <= '0;
         total_ff    <= '0;
         out_vld_ff  <= 1'b0;
      end else begin
         pend_ff     <= cmd.step;
         clr_addr_ff <= clr_addr_in;
         total_ff    <= total_in;
         out_vld_ff  <= out_vld_in;
      end
      out_ff <= out_in;
   end

   assign status.clear_last = &clr_addr_ff;
   assign status.walk_last  = (remain_ff == '0);
   assign status.out_free   = !out_vld_ff || rsp_ready;

   assign rsp_valid         = out_vld_ff;
   assign rsp_overlap_cells = out_ff;

endmodule

### rtl/grid_segment_overlap_counter.sv
// ---------------------------------------------------------------------------
// grid_segment_overlap_counter
// counts grid cells covered by two or more line segments
// ---------------------------------------------------------------------------
// usage
//   req channel: one segment per transfer (x_start, y_start, x_end, y_end)
//   rsp channel: one transfer per segment carrying the running overlap total
//   each segment is walked, drained (last cell written back) and its result
//   loaded; the hit count memory does one read and one write per cycle,
//   so the walk issues one cell per cycle (a full-grid line: 1024 cells)
//   and the next req transfer is taken the cycle after the result is loaded
//   reset: synchronous, active high; afterwards the block sweeps the whole
//   hit count memory (2^(2*COORD_BITS) cells, 1048576 at the default) to
//   zero, one cell per cycle, with req_ready low until the sweep is done
//   rsp stall: the result sits in an output register; a new segment is
//   still accepted and walked, and only its hand-off waits for rsp_ready
//   horizontal and vertical lines cover every cell between the end points,
//   any other line steps diagonally and stops at the shorter axis
// ---------------------------------------------------------------------------
module grid_segment_overlap_counter #(
   parameter int COORD_BITS = gsoc_pkg::COORD_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [gsoc_pkg::IN_BITS-1:0]     req_x_start,
   input  logic [gsoc_pkg::IN_BITS-1:0]     req_y_start,
   input  logic [gsoc_pkg::IN_BITS-1:0]     req_x_end,
   input  logic [gsoc_pkg::IN_BITS-1:0]     req_y_end,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [gsoc_pkg::TOTAL_BITS-1:0]  rsp_overlap_cells
);

   // command and status between sequencer and datapath
   gsoc_pkg::gsoc_cmd_type    cmd;
   gsoc_pkg::gsoc_status_type status;

   // sequencer: clear sweep, walk, drain, result hand-off
   gsoc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // walker, hit memory read-modify-write, total and output register
   gsoc_dpath #(
      .COORD_BITS (COORD_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_x_start       (req_x_start),
      .req_y_start       (req_y_start),
      .req_x_end         (req_x_end),
      .req_y_end         (req_y_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_overlap_cells (rsp_overlap_cells)
   );

endmodule

### tb/tb_grid_segment_overlap_counter.sv
// ---------------------------------------------------------------------------
// tb_grid_segment_overlap_counter
// self-checking bench for the grid segment overlap counter
// ---------------------------------------------------------------------------
// feeds line segments on the req channel, keeps its own copy of the per-cell
// hit counts and the running overlap total, and compares every rsp transfer
// against the oldest outstanding total; a directed set hits the grid edges,
// full-length lines in all directions and repeated single points, then a
// random set packs short segments into small windows so cells overlap often
// ---------------------------------------------------------------------------
module tb_grid_segment_overlap_counter;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          GRID_BITS  = gsoc_pkg::COORD_BITS_DEF;
   localparam int          GRID_SIDE  = 1 << GRID_BITS;
   localparam int          GRID_CELLS = 1 << (2 * GRID_BITS);
   localparam int          IN_W       = gsoc_pkg::IN_BITS;
   localparam int          TOT_W      = gsoc_pkg::TOTAL_BITS;
   localparam int unsigned TOTAL_MAX  = (1 << TOT_W) - 1;
   localparam int          RANDOM_SEGMENTS = 560;
   localparam int          HOLD_OFF_CYCLES = 600;    // long receiver stall
   localparam int          DRAIN_CYCLES    = 1040;   // longest walk plus margin
   // the clear sweep after reset keeps req_ready low while it clears the
   // full grid, which is by far the longest quiet stretch in a good run
   localparam int          QUIET_LIMIT     = 4 * GRID_CELLS;

   typedef struct {
      logic [IN_W-1:0] xs;
      logic [IN_W-1:0] ys;
      logic [IN_W-1:0] xe;
      logic [IN_W-1:0] ye;
   } segment_type;

   // ------------------------------------------------------------------------
   // overlap tracker: predicts the total after each segment and checks it
   // ------------------------------------------------------------------------
   class overlap_tracker;
      bit [1:0]                cell_hits [GRID_CELLS];
      int unsigned             running_total;
      logic [TOT_W-1:0]        totals_due [$];
      int unsigned             errors;

      function new();
         foreach (cell_hits[i]) cell_hits[i] = '0;
         running_total = 0;
         errors        = 0;
      endfunction

      function void hit_cell(int unsigned x, int unsigned y);
         int unsigned idx;
         idx = ((y % GRID_SIDE) << GRID_BITS) | (x % GRID_SIDE);
         if (cell_hits[idx] < gsoc_pkg::HIT_SAT) begin
            cell_hits[idx] = cell_hits[idx] + 2'd1;
            // a cell counts once, on the hit that brings it to saturation
            if (cell_hits[idx] == gsoc_pkg::HIT_SAT && running_total < TOTAL_MAX)
               running_total++;
         end
      endfunction

      // walk one accepted segment and queue the total it must produce
      function void note_segment(segment_type seg);
         int unsigned x0, y0, x1, y1, dx, dy, steps, x, y;
         bit          x_up, y_up;
         x0 = seg.xs % GRID_SIDE;
         y0 = seg.ys % GRID_SIDE;
         x1 = seg.xe % GRID_SIDE;
         y1 = seg.ye % GRID_SIDE;
         x_up = (x0 <= x1);
         y_up = (y0 <= y1);
         dx = x_up ? x1 - x0 : x0 - x1;
         dy = y_up ? y1 - y0 : y0 - y1;
         // straight lines run the full length, slanted ones stop at the
         // shorter axis
         if (dx != 0 && dy != 0)
            steps = ((dx < dy) ? dx : dy) + 1;
         else
            steps = ((dx > dy) ? dx : dy) + 1;
         x = x0;
         y = y0;
         for (int unsigned i = 0; i < steps; i++) begin
            hit_cell(x, y);
            if (dx != 0) x = x_up ? x + 1 : x - 1;
            if (dy != 0) y = y_up ? y + 1 : y - 1;
         end
         totals_due.insert(totals_due.size(), running_total[TOT_W-1:0]);
      endfunction

      task report(string what, logic [TOT_W-1:0] got, logic [TOT_W-1:0] want);
         $display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want);
         errors++;
      endtask

      task check_total(logic [TOT_W-1:0] got);
         logic [TOT_W-1:0] want;
         if (totals_due.size() == 0) begin
            report("result with no segment outstanding", got, '0);
         end else begin
            want = totals_due.pop_front();
            if (got !== want) report("overlap_cells", got, want);
         end
      endtask

      function int pending();
         return totals_due.size();
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // clock, reset and block ports
   // ------------------------------------------------------------------------
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [IN_W-1:0]        req_x_start = '0;
   logic [IN_W-1:0]        req_y_start = '0;
   logic [IN_W-1:0]        req_x_end   = '0;
   logic [IN_W-1:0]        req_y_end   = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [TOT_W-1:0]       rsp_overlap_cells;

   overlap_tracker tracker = new();

   bit                     calm = 1'b0;          // no idling on either side
   bit                     hold_off_rsp = 1'b0;  // ask the receiver for a long stall
   int unsigned            quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   grid_segment_overlap_counter #(
      .COORD_BITS (GRID_BITS)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_x_start       (req_x_start),
      .req_y_start       (req_y_start),
      .req_x_end         (req_x_end),
      .req_y_end         (req_y_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_overlap_cells (rsp_overlap_cells)
   );

   // ------------------------------------------------------------------------
   // result side: check every rsp transfer, and watch for a hung block
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_total(rsp_overlap_cells);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t watchdog: no transfer for %0d cycles", $realtime, QUIET_LIMIT);
         $display("tb_grid_segment_overlap_counter: done, errors");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_rsp) begin
            hold_off_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_ready <= calm || ($urandom_range(0, 99) >= 14);
         @(posedge clock);
      end
   end

   // ------------------------------------------------------------------------
   // sender side
   // ------------------------------------------------------------------------

   // offer one segment and hold it until the transfer happens
   task automatic send_segment(segment_type seg);
      req_valid   <= 1'b1;
      req_x_start <= seg.xs;
      req_y_start <= seg.ys;
      req_x_end   <= seg.xe;
      req_y_end   <= seg.ye;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_segment(seg);
      // random gap after the transfer; valid stays up when there is none
      if (!calm && $urandom_range(0, 99) < 14) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic send_points(int xs, int ys, int xe, int ye);
      segment_type seg;
      seg.xs = IN_W'(xs);
      seg.ys = IN_W'(ys);
      seg.xe = IN_W'(xe);
      seg.ye = IN_W'(ye);
      send_segment(seg);
   endtask

   function automatic int clamp_coord(int v, int lo, int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   // random segment; most land in a small window so cells get hit repeatedly
   function automatic segment_type make_segment();
      segment_type seg;
      int          lo, hi, reach, xs, ys, xe, ye, d, pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         lo = 0;                    // low corner
         hi = 23;
         reach = 23;
      end else if (pick < 75) begin
         lo = GRID_SIDE - 24;       // high corner, upper bits set
         hi = GRID_SIDE - 1;
         reach = 23;
      end else if (pick < 98) begin
         lo = 0;                    // anywhere, short
         hi = GRID_SIDE - 1;
         reach = 40;
      end else begin
         lo = 0;                    // anywhere, long
         hi = GRID_SIDE - 1;
         reach = GRID_SIDE - 1;
      end
      xs = $urandom_range(lo, hi);
      ys = $urandom_range(lo, hi);
      xe = xs;
      ye = ys;
      case ($urandom_range(0, 3))
         0: begin                   // horizontal
            xe = clamp_coord(xs + $urandom_range(0, 2 * reach) - reach, lo, hi);
         end
         1: begin                   // vertical
            ye = clamp_coord(ys + $urandom_range(0, 2 * reach) - reach, lo, hi);
         end
         2: begin                   // 45 degrees, clipping may cut one axis short
            d  = $urandom_range(0, reach);
            xe = clamp_coord($urandom_range(0, 1) ? xs + d : xs - d, lo, hi);
            ye = clamp_coord($urandom_range(0, 1) ? ys + d : ys - d, lo, hi);
         end
         default: begin             // any slope
            xe = clamp_coord(xs + $urandom_range(0, 2 * reach) - reach, lo, hi);
            ye = clamp_coord(ys + $urandom_range(0, 2 * reach) - reach, lo, hi);
         end
      endcase
      seg.xs = IN_W'(xs);
      seg.ys = IN_W'(ys);
      seg.xe = IN_W'(xe);
      seg.ye = IN_W'(ye);
      return seg;
   endfunction

   initial begin
      int top;
      top = GRID_SIDE - 1;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // single point three times: second hit counts, third is saturated
      send_points(0, 0, 0, 0);
      send_points(0, 0, 0, 0);
      send_points(0, 0, 0, 0);
      send_points(top, top, top, top);
      // full rows and columns, both directions
      send_points(0, 0, top, 0);
      send_points(top, 0, 0, 0);
      send_points(0, top, 0, 0);
      send_points(top, 0, top, top);
      // full diagonals, all four directions
      send_points(0, 0, top, top);
      send_points(top, 0, 0, top);
      send_points(top, top, 0, 0);
      send_points(0, top, top, 0);
      // slanted lines that stop at the shorter axis
      send_points(5, 3, 20, 7);
      send_points(20, 7, 5, 3);
      send_points(3, 5, 7, 20);
      send_points(512, 511, 511, 512);
      // alternating bit patterns
      send_points(341, 682, 682, 341);
      send_points(682, 341, 682, 341);
      // short crossing pair
      send_points(10, 10, 10, 12);
      send_points(8, 10, 12, 10);

      for (int n = 0; n < RANDOM_SEGMENTS; n++) begin
         // receiver goes dark while segments keep coming, so the input backs up
         if (n == 100) hold_off_rsp = 1'b1;
         // sender waits for the pipe to empty once, with nothing on offer
         if (n == 300) begin
            req_valid <= 1'b0;
            while (tracker.pending() != 0) @(posedge clock);
         end
         calm = (n >= 400 && n < 480);
         send_segment(make_segment());
      end

      req_valid <= 1'b0;
      calm = 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      // catch any stray result after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.errors == 0)
         $display("tb_grid_segment_overlap_counter: done, clean");
      else
         $display("tb_grid_segment_overlap_counter: done, errors");
      $finish;
   end

endmodule

### files.f
rtl/gsoc_pkg.sv
rtl/gsoc_ctrl.sv
rtl/gsoc_dpath.sv
rtl/grid_segment_overlap_counter.sv
tb/tb_grid_segment_overlap_counter.sv
